// ----- src/bmnt_pkg.sv -----
// ----------------------------------------------------------------------------
// bmnt_pkg: shared types and constants of the block mean nearest tile matcher
// Field widths, table sizes, item codes and the structures that travel
// between the front end, the queue and the search engine.
// ----------------------------------------------------------------------------
package bmnt_pkg;

  localparam int MAX_TILES      = 256;
  localparam int MAX_BLOCK_COLS = 256;

  localparam int TILE_IW = $clog2(MAX_TILES);
  localparam int COL_IW  = $clog2(MAX_BLOCK_COLS);

  localparam int FW_W    = 13;
  localparam int BS_W    = 7;
  localparam int NT_W    = 9;
  localparam int POS_W   = 12;
  localparam int OFF_W   = 6;
  localparam int PIX_W   = 8;
  localparam int TIDX_W  = 8;
  localparam int MEAN_W  = 16;
  localparam int SUM_W   = 20;
  localparam int AREA_W  = 13;
  localparam int PROD_W  = MEAN_W + AREA_W;
  localparam int DIST_W  = PROD_W;
  localparam int BEST_W  = 8;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = Q_AW + 1;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BLOCK_SIZE   = 2'd2;
  localparam logic [1:0] REG_NUM_TILES    = 2'd3;

  typedef struct packed {
    logic [FW_W-1:0] fw;
    logic [FW_W-1:0] fh;
    logic [BS_W-1:0] bs;
    logic [NT_W-1:0] nt;
  } cfg_t;

  typedef struct packed {
    logic              is_load;
    logic [TIDX_W-1:0] tile_idx;
    logic [MEAN_W-1:0] tile_mean;
    logic [SUM_W-1:0]  sum;
    logic [POS_W-1:0]  brow;
    logic [COL_IW-1:0] bcol;
  } q_entry_t;

endpackage

// ----- src/bmnt_front.sv -----
// ----------------------------------------------------------------------------
// bmnt_front: item intake, raster tracking and column accumulation
// Accepts one item per cycle unless stalled, tracks the pixel position, sums
// pixels of full blocks per column and queues tile loads and finished blocks.
// ----------------------------------------------------------------------------
module bmnt_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       restart,
  input  bmnt_pkg::cfg_t             cfg,
  input  logic                       in_valid,
  input  logic                       in_mode,
  input  logic [bmnt_pkg::TIDX_W-1:0] in_tile_index,
  input  logic [bmnt_pkg::MEAN_W-1:0] in_tile_mean,
  input  logic [bmnt_pkg::PIX_W-1:0]  in_pixel,
  output logic                       in_stall,
  input  logic                       q_room,
  output logic                       push,
  output bmnt_pkg::q_entry_t         push_entry
);

  logic [bmnt_pkg::POS_W-1:0] x_r, y_r, bcol_r, brow_r, bxs_r, bys_r;
  logic [bmnt_pkg::OFF_W-1:0] xo_r, yo_r;

  logic                        acc, pix_acc;
  logic [bmnt_pkg::BS_W-1:0]   bs_m1;
  logic [bmnt_pkg::FW_W-1:0]   bx_end, by_end, x_inc, y_inc;
  logic                        in_rng, xo_last, yo_last, x_last, y_last;
  logic [bmnt_pkg::COL_IW-1:0] col_addr;

  logic                        b_valid_r, b_load_r, b_wr_r, b_last_r;
  logic [bmnt_pkg::COL_IW-1:0] b_addr_r;
  logic [bmnt_pkg::PIX_W-1:0]  b_pix_r;
  logic [bmnt_pkg::POS_W-1:0]  b_brow_r;
  logic [bmnt_pkg::TIDX_W-1:0] b_tidx_r;
  logic [bmnt_pkg::MEAN_W-1:0] b_tmean_r;

  logic [bmnt_pkg::SUM_W-1:0]  sums [bmnt_pkg::MAX_BLOCK_COLS];
  logic [bmnt_pkg::MAX_BLOCK_COLS-1:0] sv_r;
  logic [bmnt_pkg::SUM_W-1:0]  sum_rd_r;
  logic                        svrd_r;

  logic                        fwd_v_r;
  logic [bmnt_pkg::COL_IW-1:0] fwd_addr_r;
  logic [bmnt_pkg::SUM_W-1:0]  fwd_data_r;

  logic                        b_we;
  logic [bmnt_pkg::SUM_W-1:0]  old_sum, new_sum, b_wdata;

  assign in_stall = ~q_room;
  assign acc      = in_valid & ~in_stall;
  assign pix_acc  = acc & (in_mode == bmnt_pkg::MODE_PIXEL);

  assign bs_m1   = cfg.bs - bmnt_pkg::BS_W'(1);
  assign bx_end  = bmnt_pkg::FW_W'(bxs_r) + bmnt_pkg::FW_W'(cfg.bs);
  assign by_end  = bmnt_pkg::FW_W'(bys_r) + bmnt_pkg::FW_W'(cfg.bs);
  assign x_inc   = bmnt_pkg::FW_W'(x_r) + bmnt_pkg::FW_W'(1);
  assign y_inc   = bmnt_pkg::FW_W'(y_r) + bmnt_pkg::FW_W'(1);
  assign in_rng  = (bx_end <= cfg.fw) && (by_end <= cfg.fh) &&
                   (32'(bcol_r) < bmnt_pkg::MAX_BLOCK_COLS);
  assign xo_last = (bmnt_pkg::BS_W'(xo_r) == bs_m1);
  assign yo_last = (bmnt_pkg::BS_W'(yo_r) == bs_m1);
  assign x_last  = (x_inc >= cfg.fw);
  assign y_last  = (y_inc >= cfg.fh);
  assign col_addr = bmnt_pkg::COL_IW'(bcol_r);

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      x_r    <= '0;
      y_r    <= '0;
      xo_r   <= '0;
      yo_r   <= '0;
      bcol_r <= '0;
      brow_r <= '0;
      bxs_r  <= '0;
      bys_r  <= '0;
    end else if (pix_acc) begin
      if (x_last) begin
        x_r    <= '0;
        xo_r   <= '0;
        bcol_r <= '0;
        bxs_r  <= '0;
        if (y_last) begin
          y_r    <= '0;
          yo_r   <= '0;
          brow_r <= '0;
          bys_r  <= '0;
        end else begin
          y_r <= bmnt_pkg::POS_W'(y_inc);
          if (yo_last) begin
            yo_r   <= '0;
            brow_r <= brow_r + bmnt_pkg::POS_W'(1);
            bys_r  <= bmnt_pkg::POS_W'(by_end);
          end else begin
            yo_r <= yo_r + bmnt_pkg::OFF_W'(1);
          end
        end
      end else begin
        x_r <= bmnt_pkg::POS_W'(x_inc);
        if (xo_last) begin
          xo_r   <= '0;
          bcol_r <= bcol_r + bmnt_pkg::POS_W'(1);
          bxs_r  <= bmnt_pkg::POS_W'(bx_end);
        end else begin
          xo_r <= xo_r + bmnt_pkg::OFF_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      b_load_r  <= (in_mode == bmnt_pkg::MODE_LOAD);
      b_wr_r    <= (in_mode == bmnt_pkg::MODE_PIXEL) && in_rng;
      b_last_r  <= xo_last && yo_last;
      b_addr_r  <= col_addr;
      b_pix_r   <= in_pixel;
      b_brow_r  <= brow_r;
      b_tidx_r  <= in_tile_index;
      b_tmean_r <= in_tile_mean;
    end
  end

  assign b_we    = b_valid_r & b_wr_r;
  assign old_sum = (fwd_v_r && (fwd_addr_r == b_addr_r)) ? fwd_data_r :
                   (svrd_r ? sum_rd_r : '0);
  assign new_sum = old_sum + bmnt_pkg::SUM_W'(b_pix_r);
  assign b_wdata = b_last_r ? '0 : new_sum;

  always_ff @(posedge clk) begin
    if (acc) begin
      sum_rd_r <= sums[col_addr];
    end
    if (b_we) begin
      sums[b_addr_r] <= b_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      sv_r    <= '0;
      svrd_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      if (acc) begin
        svrd_r <= sv_r[col_addr];
      end
      if (b_we) begin
        sv_r[b_addr_r] <= 1'b1;
      end
      fwd_v_r <= b_we;
    end
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      fwd_addr_r <= b_addr_r;
      fwd_data_r <= b_wdata;
    end
  end

  assign push = b_valid_r & (b_load_r | (b_wr_r & b_last_r));

  always_comb begin
    push_entry           = '0;
    push_entry.is_load   = b_load_r;
    push_entry.tile_idx  = b_tidx_r;
    push_entry.tile_mean = b_tmean_r;
    push_entry.sum       = new_sum;
    push_entry.brow      = b_brow_r;
    push_entry.bcol      = b_addr_r;
  end

endmodule

// ----- src/bmnt_fifo.sv -----
// ----------------------------------------------------------------------------
// bmnt_fifo: short queue between the front end and the search engine
// Holds tile loads and finished blocks in order. The room flag keeps one
// slot free for the item still in the front end's accumulate stage.
// ----------------------------------------------------------------------------
module bmnt_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bmnt_pkg::q_entry_t push_entry,
  input  logic               pop,
  output logic               q_valid,
  output bmnt_pkg::q_entry_t q_entry,
  output logic               q_room,
  output logic               q_full
);

  bmnt_pkg::q_entry_t mem [bmnt_pkg::Q_DEPTH];

  logic [bmnt_pkg::Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [bmnt_pkg::Q_CW-1:0] count_r;
  logic                      do_push, do_pop;

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == bmnt_pkg::Q_CW'(bmnt_pkg::Q_DEPTH));
  assign q_room  = (count_r <= bmnt_pkg::Q_CW'(bmnt_pkg::Q_DEPTH - 2));
  assign q_entry = mem[rd_ptr_r];
  assign do_push = push & ~q_full;
  assign do_pop  = pop & q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + bmnt_pkg::Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + bmnt_pkg::Q_AW'(1);
      end
      priority if (do_push && !do_pop) begin
        count_r <= count_r + bmnt_pkg::Q_CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - bmnt_pkg::Q_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ----- src/bmnt_back.sv -----
// ----------------------------------------------------------------------------
// bmnt_back: tile mean table and nearest tile search
// Applies queued tile loads to the table and, for each finished block, walks
// the valid tiles one per cycle through a read, multiply, distance and
// compare pipeline before handing the winner to the output register.
// ----------------------------------------------------------------------------
module bmnt_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bmnt_pkg::cfg_t              cfg,
  input  logic                        q_valid,
  input  bmnt_pkg::q_entry_t          q_entry,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bmnt_pkg::BEST_W-1:0] out_best_tile,
  output logic [bmnt_pkg::POS_W-1:0]  out_block_row,
  output logic [bmnt_pkg::POS_W-1:0]  out_block_col
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] st_r;

  logic [bmnt_pkg::MEAN_W-1:0] tmem [bmnt_pkg::MAX_TILES];

  logic                         tm_we;
  logic [bmnt_pkg::TILE_IW-1:0] tm_waddr;

  logic [bmnt_pkg::NT_W-1:0]    iss_r;
  logic                         iss_on_r, iss_last;
  logic                         v1_r, v2_r, v3_r, l1_r, l2_r, l3_r;
  logic [bmnt_pkg::TILE_IW-1:0] i1_r, i2_r, i3_r;
  logic [bmnt_pkg::MEAN_W-1:0]  rd_r;
  logic [bmnt_pkg::PROD_W-1:0]  prod_r;
  logic [bmnt_pkg::DIST_W-1:0]  dist_r, best_d_r, scaled_sum, abs_d;
  logic [bmnt_pkg::TILE_IW-1:0] best_i_r;
  logic [bmnt_pkg::SUM_W-1:0]   sum_r;
  logic [bmnt_pkg::AREA_W-1:0]  area_r;
  logic [bmnt_pkg::POS_W-1:0]   brow_r;
  logic [bmnt_pkg::COL_IW-1:0]  bcol_r;
  logic                         out_valid_r, out_load;

  assign pop      = (st_r == S_IDLE) && q_valid;
  assign tm_we    = pop && q_entry.is_load && (32'(q_entry.tile_idx) < bmnt_pkg::MAX_TILES);
  assign tm_waddr = bmnt_pkg::TILE_IW'(q_entry.tile_idx);
  assign iss_last = ((iss_r + bmnt_pkg::NT_W'(1)) == cfg.nt);
  assign out_load = (st_r == S_DONE) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (tm_we) begin
      tmem[tm_waddr] <= q_entry.tile_mean;
    end
    if (iss_on_r) begin
      rd_r <= tmem[bmnt_pkg::TILE_IW'(iss_r)];
    end
  end

  assign scaled_sum = bmnt_pkg::DIST_W'({sum_r, 8'b0});
  assign abs_d      = (scaled_sum >= prod_r) ? scaled_sum - prod_r : prod_r - scaled_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      iss_on_r <= 1'b0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
    end else begin
      v1_r <= iss_on_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      unique case (st_r)
        S_IDLE: begin
          if (pop && !q_entry.is_load) begin
            iss_on_r <= 1'b1;
            st_r     <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (iss_on_r && iss_last) begin
            iss_on_r <= 1'b0;
          end
          if (v3_r && l3_r) begin
            st_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            st_r <= S_IDLE;
          end
        end
        default: begin
          st_r     <= S_IDLE;
          iss_on_r <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !q_entry.is_load) begin
      sum_r  <= q_entry.sum;
      area_r <= bmnt_pkg::AREA_W'(cfg.bs) * bmnt_pkg::AREA_W'(cfg.bs);
      brow_r <= q_entry.brow;
      bcol_r <= q_entry.bcol;
      iss_r  <= '0;
    end else if (iss_on_r) begin
      iss_r <= iss_r + bmnt_pkg::NT_W'(1);
    end
    i1_r   <= bmnt_pkg::TILE_IW'(iss_r);
    l1_r   <= iss_last;
    i2_r   <= i1_r;
    l2_r   <= l1_r;
    prod_r <= bmnt_pkg::PROD_W'(rd_r) * bmnt_pkg::PROD_W'(area_r);
    i3_r   <= i2_r;
    l3_r   <= l2_r;
    dist_r <= abs_d;
    if (v3_r && ((i3_r == '0) || (dist_r < best_d_r))) begin
      best_d_r <= dist_r;
      best_i_r <= i3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_best_tile <= bmnt_pkg::BEST_W'(best_i_r);
      out_block_row <= brow_r;
      out_block_col <= bmnt_pkg::POS_W'(bcol_r);
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- src/block_mean_nearest_tile.sv -----
// ----------------------------------------------------------------------------
// block_mean_nearest_tile: photomosaic tile selection per square block
// Pixels and tile loads enter a front end taking one item per cycle unless
// stalled; a search engine behind a four-entry queue matches finished blocks.
// ----------------------------------------------------------------------------
// The input side takes one item per cycle, pixels or tile mean loads alike.
// Each finished block then occupies the search engine while the tile table
// is read one entry per cycle through a read, multiply, distance and compare
// pipeline; a tile load there only writes the table and starts no search.
// The input stalls only while the queue between the two halves is nearly
// full, which happens when blocks finish faster than the search keeps up,
// for example with small blocks and many tiles. A register write restarts
// the frame at its top left corner and clears all column sums at once.
module block_mean_nearest_tile (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_mode,
  input  logic [bmnt_pkg::TIDX_W-1:0] in_tile_index,
  input  logic [bmnt_pkg::MEAN_W-1:0] in_tile_mean,
  input  logic [bmnt_pkg::PIX_W-1:0]  in_pixel,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bmnt_pkg::BEST_W-1:0] out_best_tile,
  output logic [bmnt_pkg::POS_W-1:0]  out_block_row,
  output logic [bmnt_pkg::POS_W-1:0]  out_block_col,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  bmnt_pkg::cfg_t     cfg_r;
  logic               cfg_we;
  logic [1:0]         reg_idx;
  logic [bmnt_pkg::FW_W-1:0] fw_v, fh_v, fw_c, fh_c;
  logic [bmnt_pkg::BS_W-1:0] bs_v, bs_c;
  logic [bmnt_pkg::NT_W-1:0] nt_v, nt_c;

  logic               push, pop, q_valid, q_room, q_full;
  bmnt_pkg::q_entry_t push_entry, q_entry;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  assign fw_v = pwdata[bmnt_pkg::FW_W-1:0];
  assign fh_v = pwdata[bmnt_pkg::FW_W-1:0];
  assign bs_v = pwdata[bmnt_pkg::BS_W-1:0];
  assign nt_v = pwdata[bmnt_pkg::NT_W-1:0];

  always_comb begin
    fw_c = fw_v;
    if (fw_v == '0) begin
      fw_c = bmnt_pkg::FW_W'(1);
    end else if (fw_v > bmnt_pkg::FW_W'(4096)) begin
      fw_c = bmnt_pkg::FW_W'(4096);
    end
    fh_c = fh_v;
    if (fh_v == '0) begin
      fh_c = bmnt_pkg::FW_W'(1);
    end else if (fh_v > bmnt_pkg::FW_W'(4096)) begin
      fh_c = bmnt_pkg::FW_W'(4096);
    end
    bs_c = bs_v;
    if (bs_v == '0) begin
      bs_c = bmnt_pkg::BS_W'(1);
    end else if (bs_v > bmnt_pkg::BS_W'(64)) begin
      bs_c = bmnt_pkg::BS_W'(64);
    end
    nt_c = nt_v;
    if (nt_v == '0) begin
      nt_c = bmnt_pkg::NT_W'(1);
    end else if (32'(nt_v) > bmnt_pkg::MAX_TILES) begin
      nt_c = bmnt_pkg::NT_W'(bmnt_pkg::MAX_TILES);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fw <= bmnt_pkg::FW_W'(640);
      cfg_r.fh <= bmnt_pkg::FW_W'(480);
      cfg_r.bs <= bmnt_pkg::BS_W'(16);
      cfg_r.nt <= bmnt_pkg::NT_W'(1);
    end else if (cfg_we) begin
      unique case (reg_idx)
        bmnt_pkg::REG_FRAME_WIDTH:  cfg_r.fw <= fw_c;
        bmnt_pkg::REG_FRAME_HEIGHT: cfg_r.fh <= fh_c;
        bmnt_pkg::REG_BLOCK_SIZE:   cfg_r.bs <= bs_c;
        bmnt_pkg::REG_NUM_TILES:    cfg_r.nt <= nt_c;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bmnt_pkg::REG_FRAME_WIDTH:  prdata = 32'(cfg_r.fw);
      bmnt_pkg::REG_FRAME_HEIGHT: prdata = 32'(cfg_r.fh);
      bmnt_pkg::REG_BLOCK_SIZE:   prdata = 32'(cfg_r.bs);
      bmnt_pkg::REG_NUM_TILES:    prdata = 32'(cfg_r.nt);
      default:                    prdata = '0;
    endcase
  end

  bmnt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .restart       (cfg_we),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_mode       (in_mode),
    .in_tile_index (in_tile_index),
    .in_tile_mean  (in_tile_mean),
    .in_pixel      (in_pixel),
    .in_stall      (in_stall),
    .q_room        (q_room),
    .push          (push),
    .push_entry    (push_entry)
  );

  bmnt_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_room     (q_room),
    .q_full     (q_full)
  );

  bmnt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_valid       (q_valid),
    .q_entry       (q_entry),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_best_tile (out_best_tile),
    .out_block_row (out_block_row),
    .out_block_col (out_block_col)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("queue overflow on push");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("search engine popped an empty queue");

  a_full_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> in_stall)
    else $error("input accepted while the queue is full");

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule

// ----- tb/block_mean_nearest_tile_checker.sv -----
// ----------------------------------------------------------------------------
// block_mean_nearest_tile_checker: scoreboard for the tile matcher
// Watches the register port and both item channels, keeps its own copy of
// the tile table, the column sums and the raster position, predicts the
// nearest tile of every finished block and compares it with the block output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_mean_nearest_tile_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_mode,
  input  logic [bmnt_pkg::TIDX_W-1:0] in_tile_index,
  input  logic [bmnt_pkg::MEAN_W-1:0] in_tile_mean,
  input  logic [bmnt_pkg::PIX_W-1:0]  in_pixel,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [bmnt_pkg::BEST_W-1:0] out_best_tile,
  input  logic [bmnt_pkg::POS_W-1:0]  out_block_row,
  input  logic [bmnt_pkg::POS_W-1:0]  out_block_col,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        pready,
  output int                          errors,
  output int                          pending
);

  typedef struct packed {
    logic [bmnt_pkg::BEST_W-1:0] tile;
    logic [bmnt_pkg::POS_W-1:0]  row;
    logic [bmnt_pkg::POS_W-1:0]  col;
  } match_t;

  match_t                      match_q[$];
  logic [bmnt_pkg::MEAN_W-1:0] mean_tbl [bmnt_pkg::MAX_TILES];
  logic [bmnt_pkg::SUM_W-1:0]  col_sum [bmnt_pkg::MAX_BLOCK_COLS];
  logic [bmnt_pkg::POS_W-1:0]  px;
  logic [bmnt_pkg::POS_W-1:0]  py;
  logic [bmnt_pkg::FW_W-1:0]   fw;
  logic [bmnt_pkg::FW_W-1:0]   fh;
  logic [bmnt_pkg::BS_W-1:0]   bs;
  logic [bmnt_pkg::NT_W-1:0]   nt;

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) begin
      return lo;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  function automatic logic [bmnt_pkg::BEST_W-1:0] nearest_tile(
      logic [bmnt_pkg::SUM_W-1:0] sum, int unsigned area);
    logic [63:0] scaled;
    logic [63:0] target;
    logic [63:0] diff;
    logic [63:0] best_diff;
    int unsigned best;
    scaled = 64'(sum) << 8;
    best = 0;
    best_diff = '0;
    for (int t = 0; t < nt; t++) begin
      target = 64'(mean_tbl[t]) * 64'(area);
      diff = (scaled >= target) ? scaled - target : target - scaled;
      if (t == 0 || diff < best_diff) begin
        best_diff = diff;
        best = t;
      end
    end
    return bmnt_pkg::BEST_W'(best);
  endfunction

  task automatic restart_frame();
    for (int i = 0; i < bmnt_pkg::MAX_BLOCK_COLS; i++) begin
      col_sum[i] = '0;
    end
    px = '0;
    py = '0;
  endtask

  task automatic apply_register(logic [1:0] idx, logic [31:0] value);
    case (idx)
      bmnt_pkg::REG_FRAME_WIDTH: begin
        fw = bmnt_pkg::FW_W'(clamp(value[bmnt_pkg::FW_W-1:0], 1, 4096));
      end
      bmnt_pkg::REG_FRAME_HEIGHT: begin
        fh = bmnt_pkg::FW_W'(clamp(value[bmnt_pkg::FW_W-1:0], 1, 4096));
      end
      bmnt_pkg::REG_BLOCK_SIZE: begin
        bs = bmnt_pkg::BS_W'(clamp(value[bmnt_pkg::BS_W-1:0], 1, 64));
      end
      default: begin
        nt = bmnt_pkg::NT_W'(clamp(value[bmnt_pkg::NT_W-1:0], 1, bmnt_pkg::MAX_TILES));
      end
    endcase
    restart_frame();
  endtask

  task automatic take_item();
    int unsigned x;
    int unsigned y;
    int unsigned edge_len;
    int unsigned bc;
    int unsigned br;
    match_t m;
    if (in_mode == bmnt_pkg::MODE_LOAD) begin
      mean_tbl[in_tile_index] = in_tile_mean;
      return;
    end
    x = px;
    y = py;
    edge_len = bs;
    bc = x / edge_len;
    br = y / edge_len;
    if (bc < fw / edge_len && br < fh / edge_len && bc < bmnt_pkg::MAX_BLOCK_COLS) begin
      col_sum[bc] = col_sum[bc] + bmnt_pkg::SUM_W'(in_pixel);
      if (x % edge_len == edge_len - 1 && y % edge_len == edge_len - 1) begin
        m.tile = nearest_tile(col_sum[bc], edge_len * edge_len);
        m.row = bmnt_pkg::POS_W'(br);
        m.col = bmnt_pkg::POS_W'(bc);
        match_q.push_back(m);
        col_sum[bc] = '0;
      end
    end
    if (x + 1 >= fw) begin
      px = '0;
      py = (y + 1 >= fh) ? '0 : bmnt_pkg::POS_W'(y + 1);
    end else begin
      px = bmnt_pkg::POS_W'(x + 1);
    end
  endtask

  task automatic report_error(string msg);
    $display("%0t block_mean_nearest_tile_checker: %s", $time, msg);
    errors = errors + 1;
  endtask

  always @(posedge clk) begin
    match_t want;
    if (!rst_n) begin
      fw = bmnt_pkg::FW_W'(640);
      fh = bmnt_pkg::FW_W'(480);
      bs = bmnt_pkg::BS_W'(16);
      nt = bmnt_pkg::NT_W'(1);
      for (int i = 0; i < bmnt_pkg::MAX_TILES; i++) begin
        mean_tbl[i] = '0;
      end
      restart_frame();
      match_q.delete();
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        apply_register(paddr[3:2], pwdata);
      end
      if (in_valid && !in_stall) begin
        take_item();
      end
      if (out_valid && !out_stall) begin
        if (match_q.size() == 0) begin
          report_error($sformatf("unexpected result tile %0d row %0d col %0d",
                                 out_best_tile, out_block_row, out_block_col));
        end else begin
          want = match_q.pop_front();
          if (out_best_tile !== want.tile) begin
            report_error($sformatf("best_tile %0d, expected %0d (block %0d,%0d)",
                                   out_best_tile, want.tile, want.row, want.col));
          end
          if (out_block_row !== want.row) begin
            report_error($sformatf("block_row %0d, expected %0d",
                                   out_block_row, want.row));
          end
          if (out_block_col !== want.col) begin
            report_error($sformatf("block_col %0d, expected %0d",
                                   out_block_col, want.col));
          end
        end
      end
      pending <= match_q.size();
    end
  end

endmodule

// ----- tb/block_mean_nearest_tile_test.sv -----
// ----------------------------------------------------------------------------
// block_mean_nearest_tile_test: stimulus and verdict for the tile matcher
// Fills the tile table, runs directed frames for the corner cases, then
// random frame geometries and tile counts with random gaps and output stalls,
// while the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_mean_nearest_tile_test;

  localparam int SETTLE       = 300;
  localparam int WATCHDOG     = 4000;
  localparam int RANDOM_ITEMS = 700;

  logic                        clk           = 1'b0;
  logic                        rst_n         = 1'b0;
  logic                        in_valid      = 1'b0;
  logic                        in_stall;
  logic                        in_mode       = bmnt_pkg::MODE_LOAD;
  logic [bmnt_pkg::TIDX_W-1:0] in_tile_index = '0;
  logic [bmnt_pkg::MEAN_W-1:0] in_tile_mean  = '0;
  logic [bmnt_pkg::PIX_W-1:0]  in_pixel      = '0;
  logic                        out_valid;
  logic                        out_stall     = 1'b0;
  logic [bmnt_pkg::BEST_W-1:0] out_best_tile;
  logic [bmnt_pkg::POS_W-1:0]  out_block_row;
  logic [bmnt_pkg::POS_W-1:0]  out_block_col;
  logic                        psel          = 1'b0;
  logic                        penable       = 1'b0;
  logic                        pwrite        = 1'b0;
  logic [3:0]                  paddr         = '0;
  logic [31:0]                 pwdata        = '0;
  logic [31:0]                 prdata;
  logic                        pready;
  int                          errors;
  int                          pending;
  bit                          quiet         = 1'b0;
  int                          stall_run     = 0;
  int                          stuck_cycles  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  block_mean_nearest_tile dut (.*);

  block_mean_nearest_tile_checker chk (.*);

  always @(negedge clk) begin
    if (stall_run == 0) begin
      out_stall <= !quiet && ($urandom_range(0, 2) == 0);
      stall_run = $urandom_range(1, 8);
    end
    stall_run = stall_run - 1;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pwrite && pready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG) begin
      $display("block_mean_nearest_tile_test: done, errors");
      $finish;
    end
  end

  function automatic logic [bmnt_pkg::MEAN_W-1:0] rand_mean();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFF00;
      2: return 16'hFFFF;
      3: return {8'($urandom), 8'h00};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [bmnt_pkg::PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send(logic mode, logic [bmnt_pkg::TIDX_W-1:0] idx,
                      logic [bmnt_pkg::MEAN_W-1:0] mean,
                      logic [bmnt_pkg::PIX_W-1:0] pix);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_mode <= mode;
    in_tile_index <= idx;
    in_tile_mean <= mean;
    in_pixel <= pix;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic stream(int n, bit bright);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, bright ? 63 : 7) == 0) begin
        send(bmnt_pkg::MODE_LOAD, 8'($urandom), rand_mean(), 8'($urandom));
      end else begin
        send(bmnt_pkg::MODE_PIXEL, 8'($urandom), 16'($urandom),
             (bright && $urandom_range(0, 15) != 0) ? 8'hFF : rand_pixel());
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(int unsigned w, int unsigned h, int unsigned b,
                           int unsigned n);
    wait_idle();
    write_reg(bmnt_pkg::REG_FRAME_WIDTH, w);
    write_reg(bmnt_pkg::REG_FRAME_HEIGHT, h);
    write_reg(bmnt_pkg::REG_BLOCK_SIZE, b);
    write_reg(bmnt_pkg::REG_NUM_TILES, n);
  endtask

  initial begin
    int unsigned b_raw;
    int unsigned b_eff;
    int unsigned w;
    int unsigned h;
    int unsigned n_raw;
    int unsigned cnt;
    int unsigned rand_items;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Every table entry is loaded first, so no search ever reads an unwritten mean.
    for (int i = 0; i < bmnt_pkg::MAX_TILES; i++) begin
      send(bmnt_pkg::MODE_LOAD, 8'(i), rand_mean(), rand_pixel());
    end

    // One-pixel blocks: extreme pixels and means, a mid-frame load, an exact tie
    // between two means, and a wrap back to the top of the frame.
    configure(2, 2, 1, 4);
    send(bmnt_pkg::MODE_LOAD, 8'd0, 16'h0000, 8'hFF);
    send(bmnt_pkg::MODE_LOAD, 8'd1, 16'hFF00, 8'h00);
    send(bmnt_pkg::MODE_LOAD, 8'd2, 16'h6400, 8'hFF);
    send(bmnt_pkg::MODE_LOAD, 8'd3, 16'h6600, 8'h00);
    send(bmnt_pkg::MODE_PIXEL, 8'hFF, 16'hFFFF, 8'h00);
    send(bmnt_pkg::MODE_PIXEL, 8'h00, 16'h0000, 8'hFF);
    send(bmnt_pkg::MODE_LOAD, 8'hFF, 16'hFFFF, 8'h55);
    send(bmnt_pkg::MODE_PIXEL, 8'hAA, 16'h5555, 8'd101);
    send(bmnt_pkg::MODE_PIXEL, 8'h55, 16'hAAAA, 8'd200);
    send(bmnt_pkg::MODE_PIXEL, 8'h00, 16'h0000, 8'd7);

    // Partial edge blocks: the right column and the bottom row are dropped.
    configure(5, 3, 2, 4);
    for (int k = 0; k < 15; k++) begin
      send(bmnt_pkg::MODE_PIXEL, 8'($urandom), 16'($urandom), 8'(k * 37));
    end

    // Saturated register values: one-pixel-wide tall frame, then a 4096-wide
    // row whose block columns run past the accumulators.
    configure(0, 8191, 1, 2);
    stream(40, 1'b0);
    configure(8191, 0, 0, 3);
    stream(300, 1'b0);

    // A full block of mostly bright pixels with the whole table searched.
    configure(16, 16, 16, 511);
    stream(300, 1'b1);

    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if (rand_items >= RANDOM_ITEMS * 85 / 100) begin
        quiet = 1'b1;
      end
      case ($urandom_range(0, 7))
        0: b_raw = 0;
        1: b_raw = 1;
        2: b_raw = 2;
        3: b_raw = 3;
        4: b_raw = 4;
        7: b_raw = $urandom_range(64, 127);
        default: b_raw = $urandom_range(1, 8);
      endcase
      b_eff = (b_raw == 0) ? 1 : (b_raw > 64 ? 64 : b_raw);
      if (b_eff <= 8) begin
        w = b_eff * $urandom_range(1, 3) + $urandom_range(0, b_eff - 1);
        h = b_eff * $urandom_range(1, 2) + $urandom_range(0, b_eff - 1);
      end else begin
        w = $urandom_range(1, 70);
        h = $urandom_range(1, 4);
      end
      case ($urandom_range(0, 5))
        0: n_raw = 0;
        1: n_raw = 256;
        2: n_raw = $urandom_range(257, 511);
        default: n_raw = $urandom_range(1, 24);
      endcase
      cnt = w * h + $urandom_range(0, w * h);
      if (cnt > 300) begin
        cnt = 300;
      end
      configure(w, h, b_raw, n_raw);
      stream(cnt, 1'b0);
      rand_items = rand_items + cnt;
    end

    wait_idle();
    if (errors == 0 && pending == 0) begin
      $display("block_mean_nearest_tile_test: done, clean");
    end else begin
      $display("block_mean_nearest_tile_test: done, errors");
    end
    $finish;
  end

endmodule
